[hw/rtl/unsigned_divide_64_by_32_core_assert.svh]
// Assertion macros used by the divider cell RTL.
`ifndef UNSIGNED_DIVIDE_64_BY_32_CORE_ASSERT_SVH
`define UNSIGNED_DIVIDE_64_BY_32_CORE_ASSERT_SVH

// Same-cycle implication.
`define UDIV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("udiv: same-cycle check failed");

// Next-cycle implication.
`define UDIV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("udiv: next-cycle check failed");

`endif

[hw/rtl/udiv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package udiv_pkg;

    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 32;
    localparam int NUM_CELLS  = DIVIDEND_W;

    typedef struct packed {
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } request_t;

    typedef struct packed {
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
        logic                  div_by_zero;
    } result_t;

    // work: dividend bits still to consume on top, quotient bits entering at the bottom
    typedef struct packed {
        logic [DIVIDEND_W-1:0] work;
        logic [DIVISOR_W-1:0]  rem;
        logic [DIVISOR_W-1:0]  divisor;
        logic                  div_by_zero;
    } stage_t;

endpackage

`default_nettype wire

[hw/rtl/udiv_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "unsigned_divide_64_by_32_core_assert.svh"

module udiv_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              feed_valid,
    input  wire udiv_pkg::stage_t  feed,
    output logic                   stage_valid,
    output udiv_pkg::stage_t       stage
);

    logic [udiv_pkg::DIVISOR_W:0]   part;
    logic [udiv_pkg::DIVISOR_W+1:0] diff;
    logic                           ge;
    udiv_pkg::stage_t               stage_next;
    udiv_pkg::stage_t               stage_reg;
    logic                           valid_reg;

    always_comb
    begin
        part = {feed.rem, feed.work[udiv_pkg::DIVIDEND_W-1]};
        diff = {1'b0, part} - {2'b00, feed.divisor};
        ge   = !diff[udiv_pkg::DIVISOR_W+1];

        stage_next             = feed;
        stage_next.work        = {feed.work[udiv_pkg::DIVIDEND_W-2:0], ge};
        stage_next.rem         = ge ? diff[udiv_pkg::DIVISOR_W-1:0]
                                    : part[udiv_pkg::DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= feed_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

    `UDIV_ASSERT_NEXT(a_rem_bound, clk, rst_n,
        feed_valid && feed.divisor != '0 && feed.rem < feed.divisor,
        stage.rem < stage.divisor)
    `UDIV_ASSERT_NEXT(a_zero_part_no_bit, clk, rst_n,
        feed_valid && feed.divisor != '0 && feed.rem == '0 && !feed.work[udiv_pkg::DIVIDEND_W-1],
        !stage.work[0] && stage.rem == '0)
    `UDIV_ASSERT_NEXT(a_divisor_carry, clk, rst_n,
        feed_valid,
        stage.divisor == $past(feed.divisor) && stage.div_by_zero == $past(feed.div_by_zero))

endmodule

`default_nettype wire

[hw/rtl/unsigned_divide_64_by_32_core.sv]
// Pipelined 64-by-32 unsigned restoring divider, one quotient bit per cell.
// Each request passes through 64 subtract/compare cells and then one output register.
// Throughput: one request per cycle; busy is always low.
// Reset: rst_n (async, active low) clears all valid bits and done; no result is lost
// or invented outside reset. The receiver cannot stall; done is a one-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none

module unsigned_divide_64_by_32_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire udiv_pkg::request_t  request,
    output logic                     done,
    output udiv_pkg::result_t        result
);

    logic              chain_valid [0:udiv_pkg::NUM_CELLS];
    udiv_pkg::stage_t  chain       [0:udiv_pkg::NUM_CELLS];
    logic              done_reg;
    udiv_pkg::result_t result_reg;
    udiv_pkg::result_t result_next;

    assign busy = 1'b0;

    always_comb
    begin
        chain_valid[0]         = start && !busy;
        chain[0].work          = request.dividend;
        chain[0].rem           = '0;
        chain[0].divisor       = request.divisor;
        chain[0].div_by_zero   = (request.divisor == '0);
    end

    for (genvar i = 0; i < udiv_pkg::NUM_CELLS; i++)
    begin : g_cell
        udiv_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .feed_valid  (chain_valid[i]),
            .feed        (chain[i]),
            .stage_valid (chain_valid[i+1]),
            .stage       (chain[i+1])
        );
    end

    always_comb
    begin
        if (chain[udiv_pkg::NUM_CELLS].div_by_zero)
        begin
            result_next.quotient    = '0;
            result_next.remainder   = '0;
            result_next.div_by_zero = 1'b1;
        end
        else
        begin
            result_next.quotient    = chain[udiv_pkg::NUM_CELLS].work;
            result_next.remainder   = chain[udiv_pkg::NUM_CELLS].rem;
            result_next.div_by_zero = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain_valid[udiv_pkg::NUM_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
